FILE: design/sfp_pkg.sv
`default_nettype none
package sfp_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int STAR_RA_W  = 16;
  localparam int STAR_DEC_W = 16;
  localparam int MAG_W      = 8;
  localparam int PIX_W      = 14;
  localparam int COLOR_W    = 16;
  localparam int RADIUS_W   = 2;
  localparam int VIEW_W     = 12;
  localparam int FOV_W      = 25;
  localparam int CRA_W      = 25;
  localparam int CDEC_W     = 24;
  localparam int SCALE_W    = 17;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(6554);
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(65536);

  // viewport divide: numerator (fov +- 2*offset) * (size-3), denominator 2*fov
  localparam int QUO_W              = VIEW_W;
  localparam int DEN_W              = FOV_W + 1;
  localparam int NUM_W              = DEN_W + VIEW_W;
  localparam int DIV_BITS_PER_STAGE = 3;
  localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_LEFT     = 3'd0,
    CFG_VIEW_TOP      = 3'd1,
    CFG_VIEW_WIDTH    = 3'd2,
    CFG_VIEW_HEIGHT   = 3'd3,
    CFG_FIELD_OF_VIEW = 3'd4,
    CFG_CENTER_RA     = 3'd5,
    CFG_CENTER_DEC    = 3'd6,
    CFG_RA_SCALE      = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [VIEW_W-1:0]  view_left;
    logic [VIEW_W-1:0]  view_top;
    logic [VIEW_W-1:0]  view_width;
    logic [VIEW_W-1:0]  view_height;
    logic [FOV_W-1:0]   field_of_view;
    logic [CRA_W-1:0]   center_ra;
    logic [CDEC_W-1:0]  center_dec;
    logic [SCALE_W-1:0] ra_scale;
  } cfg_t;

  // one word in flight through the divider
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] rem_x;
    logic [NUM_W-1:0] rem_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic [MAG_W-1:0] mag;
  } div_t;

endpackage
`default_nettype wire

FILE: design/sfp_if.sv
`default_nettype none
interface sfp_in_if import sfp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STAR_RA_W-1:0]  star_ra;
  logic [STAR_DEC_W-1:0] star_dec;
  logic [MAG_W-1:0]      magnitude_tenths;

  modport source (output valid, star_ra, star_dec, magnitude_tenths, input ready);
  modport sink   (input valid, star_ra, star_dec, magnitude_tenths, output ready);
endinterface

interface sfp_out_if import sfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic [COLOR_W-1:0]  color;
  logic [RADIUS_W-1:0] radius;

  modport source (output valid, pixel_x, pixel_y, color, radius, input ready);
  modport sink   (input valid, pixel_x, pixel_y, color, radius, output ready);
endinterface
`default_nettype wire

FILE: design/sfp_convert.sv
`default_nettype none
// Two stages: raw star angles to fixed-point degrees, centre RA reduced mod 360,
// raw RA offset and declination offset formed.
module sfp_convert import sfp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic [STAR_RA_W-1:0]       star_ra,
  input  wire logic [STAR_DEC_W-1:0]      star_dec,
  input  wire logic [MAG_W-1:0]           mag,
  input  wire cfg_t                       cfg,
  output logic                            valid_r,
  output logic signed [ANGLE_FRAC_BITS+9:0] dp_r,
  output logic                            neg_d_r,
  output logic signed [ANGLE_FRAC_BITS+8:0] ddec_r,
  output logic [MAG_W-1:0]                mag_r
);

  localparam int F        = ANGLE_FRAC_BITS;
  localparam int RAA_W    = F + 9;
  localparam int RAN_W    = F + 26;
  localparam int DECM_W   = F + 7;
  localparam int DECN_W   = F + 23;
  localparam int HI_W     = CRA_W - F;
  localparam int RR_W     = HI_W + 10;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 32;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(11930464); // floor(2^32/360)
  localparam int CMP_W    = (CRA_W > RAA_W) ? CRA_W : RAA_W;
  localparam int CL_W     = ((CDEC_W > F + 8) ? CDEC_W : F + 8) + 1;

  // n / 65535 by folding 16-bit digits, then one correction
  function automatic logic [RAA_W-1:0] div_65535(input logic [RAN_W-1:0] n);
    logic [RAN_W-1:0] q;
    logic [RAN_W-1:0] r;
    q = '0;
    r = n;
    for (int i = 0; i < 4; i++) begin
      q = q + (r >> 16);
      r = (r >> 16) + RAN_W'(r[15:0]);
    end
    if (r >= RAN_W'(65535)) q = q + RAN_W'(1);
    return q[RAA_W-1:0];
  endfunction

  function automatic logic [DECM_W-1:0] div_32767(input logic [DECN_W-1:0] n);
    logic [DECN_W-1:0] q;
    logic [DECN_W-1:0] r;
    q = '0;
    r = n;
    for (int i = 0; i < 4; i++) begin
      q = q + (r >> 15);
      r = (r >> 15) + DECN_W'(r[14:0]);
    end
    if (r >= DECN_W'(32767)) q = q + DECN_W'(1);
    return q[DECM_W-1:0];
  endfunction

  // stage 1
  logic [24:0]                 ra_prod;
  logic [RAN_W-1:0]            ra_num;
  logic [STAR_DEC_W-1:0]       dec_abs;
  logic [21:0]                 dec_prod;
  logic [DECN_W-1:0]           dec_num;
  logic [DECM_W-1:0]           dec_mag;
  logic signed [F+7:0]         deca_nxt;
  logic [HI_W+RECIP_W-1:0]     hi_prod;
  logic [HI_W-1:0]             hi;

  logic                        v1_r;
  logic [RAA_W-1:0]            ra_a_r;
  logic signed [F+7:0]         deca_r;
  logic [HI_W-1:0]             qh_r;
  logic [MAG_W-1:0]            mag1_r;

  always_comb begin
    ra_prod  = 25'(star_ra) * 25'(360);
    ra_num   = RAN_W'({ra_prod, {F{1'b0}}}) + RAN_W'(32767);
    dec_abs  = star_dec[STAR_DEC_W-1] ? STAR_DEC_W'(-star_dec) : star_dec;
    dec_prod = 22'(dec_abs) * 22'(90);
    dec_num  = DECN_W'({dec_prod, {F{1'b0}}}) + DECN_W'(16383);
    dec_mag  = div_32767(dec_num);
    deca_nxt = star_dec[STAR_DEC_W-1] ? -$signed({1'b0, dec_mag}) : $signed({1'b0, dec_mag});
    hi       = cfg.center_ra[CRA_W-1:F];
    hi_prod  = (HI_W+RECIP_W)'(hi) * (HI_W+RECIP_W)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      ra_a_r <= div_65535(ra_num);
      deca_r <= deca_nxt;
      qh_r   <= HI_W'(hi_prod >> RECIP_SH);
      mag1_r <= mag;
    end
  end

  // stage 2
  logic [RR_W-1:0]             rr0;
  logic [RR_W-1:0]             rr;
  logic [RAA_W-1:0]            c_mod;
  logic signed [CL_W-1:0]      cd;
  logic signed [CL_W-1:0]      lim;
  logic signed [CL_W-1:0]      cd_cl;
  logic signed [F+7:0]         cdc;

  always_comb begin
    rr0   = RR_W'(hi) - RR_W'(qh_r) * RR_W'(360);
    rr    = (rr0 >= RR_W'(360)) ? rr0 - RR_W'(360) : rr0;
    c_mod = {rr[8:0], cfg.center_ra[F-1:0]};
    cd    = CL_W'($signed(cfg.center_dec));
    lim   = CL_W'(longint'(90) << F);
    if (cd > lim)       cd_cl = lim;
    else if (cd < -lim) cd_cl = -lim;
    else                cd_cl = cd;
    cdc   = (F+8)'(cd_cl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= v1_r;
    end
    if (adv) begin
      dp_r    <= $signed({1'b0, ra_a_r}) - $signed({1'b0, c_mod});
      neg_d_r <= CMP_W'(cfg.center_ra) > CMP_W'(ra_a_r);
      ddec_r  <= (F+9)'(deca_r) - (F+9)'(cdc);
      mag_r   <= mag1_r;
    end
  end

endmodule
`default_nettype wire

FILE: design/sfp_project.sv
`default_nettype none
// Four stages: wrap, RA scaling, rounding with field test, viewport scaling.
module sfp_project import sfp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic signed [ANGLE_FRAC_BITS+9:0] dp,
  input  wire logic                         neg_d,
  input  wire logic signed [ANGLE_FRAC_BITS+8:0] ddec,
  input  wire logic [MAG_W-1:0]             mag,
  input  wire cfg_t                         cfg,
  output div_t                              out_r
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int DP_W  = F + 10;
  localparam int DD_W  = F + 9;
  localparam int WM_W  = F + 8;
  localparam int PR_W  = F + 25;
  localparam int VW    = ((F + 9 > FOV_W) ? F + 9 : FOV_W) + 1;
  localparam int NX_W  = ((DD_W + 1 > FOV_W + 1) ? DD_W + 1 : FOV_W + 1) + 1;
  localparam logic signed [DP_W-1:0] HALF = DP_W'(longint'(180) << F);
  localparam logic signed [DP_W-1:0] FULL = DP_W'(longint'(360) << F);

  // stage 3: wrap into +-180 degrees
  logic signed [DP_W-1:0] w;
  logic [WM_W-1:0]        wmag;
  logic                   v3_r;
  logic                   wneg3_r;
  logic [WM_W-1:0]        wmag3_r;
  logic signed [DD_W-1:0] ddec3_r;
  logic [MAG_W-1:0]       mag3_r;

  always_comb begin
    if (dp > HALF)                       w = dp - FULL;
    else if (dp < -HALF)                 w = dp + FULL;
    else if (dp == HALF || dp == -HALF)  w = neg_d ? -HALF : HALF;
    else                                 w = dp;
    wmag = WM_W'(w[DP_W-1] ? -w : w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= in_valid;
    end
    if (adv) begin
      wneg3_r <= w[DP_W-1];
      wmag3_r <= wmag;
      ddec3_r <= ddec;
      mag3_r  <= mag;
    end
  end

  // stage 4: scale multiply, declination field test
  logic [SCALE_W-1:0]     sc;
  logic [WM_W-1:0]        dabs;
  logic                   v4_r;
  logic                   wneg4_r;
  logic [PR_W-1:0]        prod4_r;
  logic signed [DD_W-1:0] ddec4_r;
  logic                   decvis4_r;
  logic [MAG_W-1:0]       mag4_r;

  always_comb begin
    if (cfg.ra_scale < SCALE_MIN)      sc = SCALE_MIN;
    else if (cfg.ra_scale > SCALE_MAX) sc = SCALE_MAX;
    else                               sc = cfg.ra_scale;
    dabs = WM_W'(ddec3_r[DD_W-1] ? -ddec3_r : ddec3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      wneg4_r   <= wneg3_r;
      prod4_r   <= PR_W'(wmag3_r) * PR_W'(sc);
      ddec4_r   <= ddec3_r;
      decvis4_r <= VW'({dabs, 1'b0}) <= VW'(cfg.field_of_view);
      mag4_r    <= mag3_r;
    end
  end

  // stage 5: round, RA field test, numerators
  logic [PR_W:0]          rs;
  logic [WM_W-1:0]        rmag;
  logic signed [DD_W-1:0] dra;
  logic signed [NX_W-1:0] fov_s;
  logic signed [NX_W-1:0] nx;
  logic signed [NX_W-1:0] ny;
  logic                   enabled;
  logic                   keep;
  logic                   v5_r;
  logic [DEN_W-1:0]       nx5_r;
  logic [DEN_W-1:0]       ny5_r;
  logic [MAG_W-1:0]       mag5_r;

  always_comb begin
    rs      = (PR_W+1)'(prod4_r) + (PR_W+1)'(32768);
    rmag    = WM_W'(rs >> 16);
    dra     = wneg4_r ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    fov_s   = $signed(NX_W'(cfg.field_of_view));
    nx      = (NX_W'(dra) <<< 1) + fov_s;
    ny      = fov_s - (NX_W'(ddec4_r) <<< 1);
    enabled = (cfg.view_width > VIEW_W'(2)) && (cfg.view_height > VIEW_W'(2))
              && (cfg.field_of_view != '0);
    keep    = v4_r && enabled && decvis4_r
              && (VW'({rmag, 1'b0}) <= VW'(cfg.field_of_view));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= keep;
    end
    if (adv) begin
      nx5_r  <= DEN_W'(nx);
      ny5_r  <= DEN_W'(ny);
      mag5_r <= mag4_r;
    end
  end

  // stage 6: times (size - 3)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r.valid <= v5_r;
    end
    if (adv) begin
      out_r.rem_x <= NUM_W'(nx5_r) * NUM_W'(cfg.view_width - VIEW_W'(3));
      out_r.rem_y <= NUM_W'(ny5_r) * NUM_W'(cfg.view_height - VIEW_W'(3));
      out_r.quo_x <= '0;
      out_r.quo_y <= '0;
      out_r.mag   <= mag5_r;
    end
  end

endmodule
`default_nettype wire

FILE: design/sfp_div_stage.sv
`default_nettype none
// Restoring divide, a few quotient bits per stage, both axes side by side.
module sfp_div_stage import sfp_pkg::*; #(
  parameter int HI_BIT = QUO_W - 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [FOV_W-1:0] fov,
  input  wire div_t             d_in,
  output div_t                  d_out_r
);

  logic [NUM_W-1:0] den_k;
  div_t             nxt;

  always_comb begin
    nxt   = d_in;
    den_k = '0;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      den_k = NUM_W'({fov, 1'b0}) << (HI_BIT - j);
      if (nxt.rem_x >= den_k) begin
        nxt.rem_x               = nxt.rem_x - den_k;
        nxt.quo_x[HI_BIT - j]   = 1'b1;
      end
      if (nxt.rem_y >= den_k) begin
        nxt.rem_y               = nxt.rem_y - den_k;
        nxt.quo_y[HI_BIT - j]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r.valid <= 1'b0;
    end else if (adv) begin
      d_out_r.valid <= nxt.valid;
    end
    if (adv) begin
      d_out_r.rem_x <= nxt.rem_x;
      d_out_r.rem_y <= nxt.rem_y;
      d_out_r.quo_x <= nxt.quo_x;
      d_out_r.quo_y <= nxt.quo_y;
      d_out_r.mag   <= nxt.mag;
    end
  end

endmodule
`default_nettype wire

FILE: design/star_field_projector_unit.sv
`default_nettype none
// Star field projector: one catalog star word in, zero or one pixel word out.
// Fully pipelined: a new star is taken every cycle unless the output stalls,
// and a visible star passes 2 conversion stages, 4 projection stages, 4
// divider stages of 3 quotient bits each and 1 output register. Stars
// outside the field, or any star while the viewport or field is disabled,
// give no word. When the output is stalled the whole pipeline holds, so
// in_star.ready follows out_proj.ready whenever the output register is full.
// Configuration is taken from cfg_wr_en/cfg_index/cfg_wdata and must only
// change while no star is in flight.
module star_field_projector_unit import sfp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sfp_in_if.sink                     in_star,
  sfp_out_if.source                  out_proj,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int F = ANGLE_FRAC_BITS;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.view_left     <= '0;
      cfg_r.view_top      <= '0;
      cfg_r.view_width    <= '0;
      cfg_r.view_height   <= '0;
      cfg_r.field_of_view <= '0;
      cfg_r.center_ra     <= '0;
      cfg_r.center_dec    <= '0;
      cfg_r.ra_scale      <= SCALE_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VIEW_LEFT:     cfg_r.view_left     <= cfg_wdata[VIEW_W-1:0];
        CFG_VIEW_TOP:      cfg_r.view_top      <= cfg_wdata[VIEW_W-1:0];
        CFG_VIEW_WIDTH:    cfg_r.view_width    <= cfg_wdata[VIEW_W-1:0];
        CFG_VIEW_HEIGHT:   cfg_r.view_height   <= cfg_wdata[VIEW_W-1:0];
        CFG_FIELD_OF_VIEW: cfg_r.field_of_view <= cfg_wdata[FOV_W-1:0];
        CFG_CENTER_RA:     cfg_r.center_ra     <= cfg_wdata[CRA_W-1:0];
        CFG_CENTER_DEC:    cfg_r.center_dec    <= cfg_wdata[CDEC_W-1:0];
        CFG_RA_SCALE:      cfg_r.ra_scale      <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic adv;

  assign adv           = !out_valid_r || out_proj.ready;
  assign in_star.ready = adv;

  logic                cv_valid;
  logic signed [F+9:0] cv_dp;
  logic                cv_neg_d;
  logic signed [F+8:0] cv_ddec;
  logic [MAG_W-1:0]    cv_mag;

  sfp_convert #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_convert (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_star.valid),
    .star_ra  (in_star.star_ra),
    .star_dec (in_star.star_dec),
    .mag      (in_star.magnitude_tenths),
    .cfg      (cfg_r),
    .valid_r  (cv_valid),
    .dp_r     (cv_dp),
    .neg_d_r  (cv_neg_d),
    .ddec_r   (cv_ddec),
    .mag_r    (cv_mag)
  );

  div_t div_chain [DIV_STAGES+1];

  sfp_project #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_project (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (cv_valid),
    .dp       (cv_dp),
    .neg_d    (cv_neg_d),
    .ddec     (cv_ddec),
    .mag      (cv_mag),
    .cfg      (cfg_r),
    .out_r    (div_chain[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    sfp_div_stage #(.HI_BIT(QUO_W - 1 - s * DIV_BITS_PER_STAGE)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .fov     (cfg_r.field_of_view),
      .d_in    (div_chain[s]),
      .d_out_r (div_chain[s+1])
    );
  end

  function automatic logic [COLOR_W-1:0] red_color(input logic signed [MAG_W-1:0] m);
    logic [4:0] r;
    if (m <= 8'sd10)      r = 5'd31;
    else if (m <= 8'sd20) r = 5'd24;
    else if (m <= 8'sd30) r = 5'd18;
    else if (m <= 8'sd40) r = 5'd13;
    else                  r = 5'd8;
    return {r, 11'd0};
  endfunction

  function automatic logic [RADIUS_W-1:0] star_radius(input logic signed [MAG_W-1:0] m);
    if (m <= 8'sd10) return RADIUS_W'(2);
    if (m <= 8'sd28) return RADIUS_W'(1);
    return RADIUS_W'(0);
  endfunction

  div_t                fin;
  logic [PIX_W-1:0]    px_r;
  logic [PIX_W-1:0]    py_r;
  logic [COLOR_W-1:0]  color_r;
  logic [RADIUS_W-1:0] radius_r;

  assign fin = div_chain[DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
    if (adv) begin
      px_r     <= PIX_W'($signed(cfg_r.view_left)) + PIX_W'(1) + PIX_W'(fin.quo_x);
      py_r     <= PIX_W'($signed(cfg_r.view_top)) + PIX_W'(1) + PIX_W'(fin.quo_y);
      color_r  <= red_color($signed(fin.mag));
      radius_r <= star_radius($signed(fin.mag));
    end
  end

  assign out_proj.valid   = out_valid_r;
  assign out_proj.pixel_x = px_r;
  assign out_proj.pixel_y = py_r;
  assign out_proj.color   = color_r;
  assign out_proj.radius  = radius_r;

endmodule
`default_nettype wire
